/* hw/rtl/mu8v_pkg.sv */
`default_nettype none
package mu8v_pkg;

	// byte classes
	localparam logic [7:0] ZERO_BYTE     = 8'h00;
	localparam logic [7:0] LEAD2_MASK    = 8'he0;
	localparam logic [7:0] LEAD2_CODE    = 8'hc0;
	localparam logic [7:0] LEAD3_MASK    = 8'hf0;
	localparam logic [7:0] LEAD3_CODE    = 8'he0;
	localparam logic [7:0] CONT_MASK     = 8'hc0;
	localparam logic [7:0] CONT_CODE     = 8'h80;

	// continuation counts of a sequence
	localparam logic [1:0] EXTRA_NONE    = 2'd0;
	localparam logic [1:0] EXTRA_TWO     = 2'd1;
	localparam logic [1:0] EXTRA_THREE   = 2'd2;

	// smallest values that need two or three bytes
	localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
	localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

	localparam int unsigned TDATA_W = 8;

	typedef struct packed {
		logic        error_seen;
		logic [1:0]  bytes_pending;
		logic [1:0]  sequence_extra;
		logic [15:0] code_accum;
		logic        overlong_seen;
	} mu8v_state_t;

	typedef struct packed {
		logic verdict_ready;
		logic string_valid;
		logic overlong_warning;
	} mu8v_result_t;

endpackage
`default_nettype wire

/* hw/rtl/mu8v_step.sv */
`default_nettype none
module mu8v_step (
	input  wire logic [7:0]           byte_value,
	input  wire logic                 last_byte,
	input  wire logic                 liberal_mode,
	input  wire mu8v_pkg::mu8v_state_t cur,
	output mu8v_pkg::mu8v_state_t     nxt,
	output mu8v_pkg::mu8v_result_t    res
);

	mu8v_pkg::mu8v_state_t upd;
	logic [15:0]           accum_new;
	logic [1:0]            pend_new;
	logic [15:0]           limit;

	assign accum_new = {cur.code_accum[9:0], byte_value[5:0]};
	assign pend_new  = cur.bytes_pending - 2'd1;
	assign limit     = (cur.sequence_extra == mu8v_pkg::EXTRA_TWO) ?
		mu8v_pkg::TWO_BYTE_MIN : mu8v_pkg::THREE_BYTE_MIN;

	always_comb begin
		upd = cur;
		if (!cur.error_seen) begin
			if (cur.bytes_pending == 2'd0) begin
				priority if (byte_value == mu8v_pkg::ZERO_BYTE) begin
					upd.error_seen = 1'b1;
				end else if (byte_value[7] == 1'b0) begin
					upd.error_seen = 1'b0;
				end else if ((byte_value & mu8v_pkg::LEAD2_MASK) == mu8v_pkg::LEAD2_CODE) begin
					upd.sequence_extra = mu8v_pkg::EXTRA_TWO;
					upd.bytes_pending  = mu8v_pkg::EXTRA_TWO;
					upd.code_accum     = {11'd0, byte_value[4:0]};
				end else if ((byte_value & mu8v_pkg::LEAD3_MASK) == mu8v_pkg::LEAD3_CODE) begin
					upd.sequence_extra = mu8v_pkg::EXTRA_THREE;
					upd.bytes_pending  = mu8v_pkg::EXTRA_THREE;
					upd.code_accum     = {12'd0, byte_value[3:0]};
				end else begin
					upd.error_seen = 1'b1;
				end
			end else if ((byte_value & mu8v_pkg::CONT_MASK) != mu8v_pkg::CONT_CODE) begin
				upd.error_seen = 1'b1;
			end else begin
				upd.code_accum    = accum_new;
				upd.bytes_pending = pend_new;
				if (pend_new == 2'd0) begin
					if (accum_new == 16'd0) begin
						// decoded zero is legal only as C0 80
						if (cur.sequence_extra != mu8v_pkg::EXTRA_TWO) begin
							upd.error_seen = 1'b1;
						end
					end else if (accum_new < limit) begin
						upd.overlong_seen = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res.verdict_ready    = last_byte;
		res.string_valid     = !(upd.error_seen || (last_byte && (upd.bytes_pending != 2'd0)));
		res.overlong_warning = upd.overlong_seen && !liberal_mode;
		nxt = last_byte ? '0 : upd;
	end

endmodule
`default_nettype wire

/* hw/rtl/modified_utf8_stream_validator.sv */
// An accepted input beat goes through the input register, then the result register.
// Throughput: one byte per clock unless the sink stalls; per-string state updates per byte.
// Input register and result register each hold one beat; while the result is stalled, the
// next byte is taken into the input register only if that register is empty.
// Reset: arst_n clears both registers' valid flags, the decode state and liberal_mode.
`default_nettype none
module modified_utf8_stream_validator #(
	parameter int unsigned TDATA_W = mu8v_pkg::TDATA_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data,   // liberal_mode
	input  wire logic               s_axis_tvalid,
	output      logic               s_axis_tready,
	input  wire logic [TDATA_W-1:0] s_axis_tdata,  // [7:0] byte_value
	input  wire logic               s_axis_tlast,  // last_byte
	output      logic               m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output      logic [TDATA_W-1:0] m_axis_tdata,  // [0] string_valid, [1] overlong_warning
	output      logic               m_axis_tlast   // verdict_ready
);

	logic                   liberal_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   valid_s2;
	mu8v_pkg::mu8v_result_t res_s2;
	mu8v_pkg::mu8v_state_t  state_q;
	mu8v_pkg::mu8v_state_t  state_nxt;
	mu8v_pkg::mu8v_result_t res_nxt;
	logic                   advance;
	logic                   fire;

	assign advance       = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	mu8v_step u_step (
		.byte_value   (byte_s1),
		.last_byte    (last_s1),
		.liberal_mode (liberal_q),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liberal_q <= 1'b0;
		end else if (cfg_wr_en) begin
			liberal_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// hold the result beat while the sink stalls
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = res_s2.verdict_ready;
	assign m_axis_tdata  = {{(TDATA_W-2){1'b0}}, res_s2.overlong_warning, res_s2.string_valid};

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.error_seen && !(fire && last_s1)) |=> state_q.error_seen)
		else $error("error flag dropped inside a string");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (state_q == '0))
		else $error("string state not cleared after last byte");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_pending <= state_q.sequence_extra)
		else $error("more continuation bytes pending than the sequence holds");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input refused with empty input register");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("result beat changed while stalled");

endmodule
`default_nettype wire
